>>> rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// shared widths, operation and status codes, the slot entry struct and controller/datapath structs
// for the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 1024;
    localparam int unsigned CNT_W_DEF      = $clog2(SLOT_COUNT_DEF + 1);

    localparam int unsigned OP_W     = 3;
    localparam int unsigned ST_W     = 2;
    localparam int unsigned HANDLE_W = 64;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned REF_W    = 32;
    localparam int unsigned GEN_W    = 32;
    localparam int unsigned LOW_W    = 32;

    localparam logic [OP_W-1:0] OP_ALLOCATE = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE     = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_REF  = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    // one slot entry as held in the slot memory
    typedef struct packed {
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] tag;
        logic [REF_W-1:0]  refs;
        logic              alive;
        logic [GEN_W-1:0]  gen;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic ready;
        logic accept;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/ght_if.sv
// ----------------------------------------------------------------------------
// ght_if
// valid/ready channels for request beats and result beats
// ----------------------------------------------------------------------------
interface ght_in_if;
    logic                           valid;
    logic                           ready;
    logic [ght_pkg::OP_W-1:0]       operation;
    logic [ght_pkg::HANDLE_W-1:0]   handle;
    logic [ght_pkg::DATA_W-1:0]     payload;
    logic [ght_pkg::DATA_W-1:0]     type_tag;

    modport source (output valid, operation, handle, payload, type_tag, input ready);
    modport sink   (input valid, operation, handle, payload, type_tag, output ready);
endinterface

interface ght_out_if #(
    parameter int unsigned CNT_W = ght_pkg::CNT_W_DEF
);
    logic                           valid;
    logic                           ready;
    logic [ght_pkg::ST_W-1:0]       status;
    logic [ght_pkg::HANDLE_W-1:0]   new_handle;
    logic [ght_pkg::DATA_W-1:0]     payload_out;
    logic [ght_pkg::DATA_W-1:0]     type_out;
    logic [ght_pkg::REF_W-1:0]      ref_count;
    logic                           reached_zero;
    logic [CNT_W-1:0]               live_count;

    modport source (output valid, status, new_handle, payload_out, type_out, ref_count,
                    reached_zero, live_count, input ready);
    modport sink   (input valid, status, new_handle, payload_out, type_out, ref_count,
                    reached_zero, live_count, output ready);
endinterface

>>> rtl/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// two-state sequencer: take a request beat, then commit it once the result
// register can take the result
// ----------------------------------------------------------------------------
module ght_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ght_pkg::t_stat i_stat,
    output ght_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.ready  = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_stat.in_valid;
                if (i_stat.in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // slot read data is in hand, hold until result register frees
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_accept_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.accept && o_cmd.commit))
        else $error("accept and commit in the same cycle");

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_stat.out_free)
        else $error("commit while result register is busy");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_cmd.ready)
        else $error("ready right after an accepted beat");

endmodule

>>> rtl/ght_dp.sv
// ----------------------------------------------------------------------------
// ght_dp
// slot memory, free stack memory, table counters and result register
// ----------------------------------------------------------------------------
module ght_dp #(
    parameter int unsigned SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ght_pkg::t_cmd  i_cmd,
    output ght_pkg::t_stat o_stat,
    ght_in_if.sink         i_in,
    ght_out_if.source      o_out
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int unsigned GEN_W = ght_pkg::GEN_W;
    localparam int unsigned LOW_W = ght_pkg::LOW_W;

    // memories
    ght_pkg::t_slot   r_slot_mem   [SLOT_COUNT];
    logic [IDX_W-1:0] r_fs_idx_mem [SLOT_COUNT];
    logic [GEN_W-1:0] r_fs_gen_mem [SLOT_COUNT];

    ght_pkg::t_slot   r_slot_rd;
    logic [IDX_W-1:0] r_fs_idx_rd;
    logic [GEN_W-1:0] r_fs_gen_rd;

    // table counters
    logic [CNT_W-1:0] r_fdepth, n_fdepth;
    logic [CNT_W-1:0] r_hw, n_hw;
    logic [CNT_W-1:0] r_live, n_live;

    // captured request
    logic [ght_pkg::OP_W-1:0]   r_op;
    logic [GEN_W-1:0]           r_hgen;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_hin_ok;
    logic [ght_pkg::DATA_W-1:0] r_pay;
    logic [ght_pkg::DATA_W-1:0] r_typ;

    // result register
    logic                         r_out_valid;
    logic [ght_pkg::ST_W-1:0]     r_status, n_status;
    logic [ght_pkg::HANDLE_W-1:0] r_new_handle, n_new_handle;
    logic [ght_pkg::DATA_W-1:0]   r_pay_out, n_pay_out;
    logic [ght_pkg::DATA_W-1:0]   r_typ_out, n_typ_out;
    logic [ght_pkg::REF_W-1:0]    r_refs_out, n_refs_out;
    logic                         r_zero_out, n_zero_out;

    // request decode
    logic [LOW_W-1:0] hlow;
    logic [LOW_W-1:0] hidx;
    logic             hin_ok;
    logic [IDX_W-1:0] fs_top;

    // execute
    logic             h_ok;
    logic             got;
    logic             slot_we;
    logic             fs_push;
    logic [IDX_W-1:0] wr_idx;
    logic [GEN_W-1:0] alloc_gen;
    ght_pkg::t_slot   slot_wr;

    assign i_in.ready = i_cmd.ready;

    assign o_stat.in_valid = i_in.valid;
    assign o_stat.out_free = !r_out_valid || o_out.ready;

    assign hlow   = i_in.handle[LOW_W-1:0];
    assign hidx   = hlow - LOW_W'(1);
    assign hin_ok = (hlow != '0) && (hidx < LOW_W'(r_hw));
    assign fs_top = IDX_W'(r_fdepth - CNT_W'(1));

    // capture the request and issue both memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= i_in.operation;
            r_hgen      <= i_in.handle[ght_pkg::HANDLE_W-1:LOW_W];
            r_idx       <= IDX_W'(hidx);
            r_hin_ok    <= hin_ok;
            r_pay       <= i_in.payload;
            r_typ       <= i_in.type_tag;
            r_slot_rd   <= r_slot_mem[IDX_W'(hidx)];
            r_fs_idx_rd <= r_fs_idx_mem[fs_top];
            r_fs_gen_rd <= r_fs_gen_mem[fs_top];
        end
    end

    assign h_ok = r_hin_ok && r_slot_rd.alive && (r_slot_rd.gen == r_hgen);

    always_comb begin
        n_status     = ght_pkg::ST_INVALID;
        n_new_handle = '0;
        n_pay_out    = '0;
        n_typ_out    = '0;
        n_refs_out   = '0;
        n_zero_out   = 1'b0;
        n_fdepth     = r_fdepth;
        n_hw         = r_hw;
        n_live       = r_live;
        got          = 1'b0;
        slot_we      = 1'b0;
        fs_push      = 1'b0;
        wr_idx       = r_idx;
        alloc_gen    = '0;
        slot_wr      = r_slot_rd;
        case (r_op)
            ght_pkg::OP_ALLOCATE: begin
                // reuse the last freed slot first, else extend the mark
                if (r_fdepth != '0) begin
                    got       = 1'b1;
                    wr_idx    = r_fs_idx_rd;
                    alloc_gen = r_fs_gen_rd;
                    n_fdepth  = r_fdepth - CNT_W'(1);
                end else if (r_hw < CNT_W'(SLOT_COUNT)) begin
                    got       = 1'b1;
                    wr_idx    = IDX_W'(r_hw);
                    n_hw      = r_hw + CNT_W'(1);
                end
                if (got) begin
                    slot_we       = 1'b1;
                    slot_wr.payload = r_pay;
                    slot_wr.tag   = r_typ;
                    slot_wr.refs  = ght_pkg::REF_W'(1);
                    slot_wr.alive = 1'b1;
                    slot_wr.gen   = alloc_gen;
                    n_live        = r_live + CNT_W'(1);
                    n_status      = ght_pkg::ST_OK;
                    n_new_handle  = {alloc_gen, LOW_W'(wr_idx) + LOW_W'(1)};
                    n_refs_out    = ght_pkg::REF_W'(1);
                end else begin
                    n_status = ght_pkg::ST_FULL;
                end
            end
            ght_pkg::OP_FREE: begin
                if (h_ok) begin
                    slot_we         = 1'b1;
                    slot_wr.payload = '0;
                    slot_wr.refs    = '0;
                    slot_wr.alive   = 1'b0;
                    slot_wr.gen     = r_slot_rd.gen + GEN_W'(1);
                    // the stack keeps the bumped generation next to the index
                    if (r_fdepth < CNT_W'(SLOT_COUNT)) begin
                        fs_push  = 1'b1;
                        n_fdepth = r_fdepth + CNT_W'(1);
                    end
                    if (r_live != '0) begin
                        n_live = r_live - CNT_W'(1);
                    end
                    n_status = ght_pkg::ST_OK;
                end
            end
            ght_pkg::OP_ADD_REF: begin
                if (h_ok) begin
                    slot_we = 1'b1;
                    if (r_slot_rd.refs != ght_pkg::REF_MAX) begin
                        slot_wr.refs = r_slot_rd.refs + ght_pkg::REF_W'(1);
                    end
                    n_refs_out = slot_wr.refs;
                    n_status   = ght_pkg::ST_OK;
                end
            end
            ght_pkg::OP_RELEASE: begin
                if (h_ok) begin
                    slot_we = 1'b1;
                    if (r_slot_rd.refs != '0) begin
                        slot_wr.refs = r_slot_rd.refs - ght_pkg::REF_W'(1);
                    end
                    n_zero_out = (r_slot_rd.refs == ght_pkg::REF_W'(1));
                    n_refs_out = slot_wr.refs;
                    n_status   = ght_pkg::ST_OK;
                end
            end
            ght_pkg::OP_LOOKUP: begin
                if (h_ok) begin
                    n_pay_out  = r_slot_rd.payload;
                    n_typ_out  = r_slot_rd.tag;
                    n_refs_out = r_slot_rd.refs;
                    n_status   = ght_pkg::ST_OK;
                end
            end
            default: begin
                n_status = ght_pkg::ST_INVALID;
            end
        endcase
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && slot_we) begin
            r_slot_mem[wr_idx] <= slot_wr;
        end
        if (i_cmd.commit && fs_push) begin
            r_fs_idx_mem[IDX_W'(r_fdepth)] <= r_idx;
            r_fs_gen_mem[IDX_W'(r_fdepth)] <= slot_wr.gen;
        end
    end

    // counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdepth    <= '0;
            r_hw        <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_fdepth    <= n_fdepth;
                r_hw        <= n_hw;
                r_live      <= n_live;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status     <= n_status;
            r_new_handle <= n_new_handle;
            r_pay_out    <= n_pay_out;
            r_typ_out    <= n_typ_out;
            r_refs_out   <= n_refs_out;
            r_zero_out   <= n_zero_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.new_handle   = r_new_handle;
    assign o_out.payload_out  = r_pay_out;
    assign o_out.type_out     = r_typ_out;
    assign o_out.ref_count    = r_refs_out;
    assign o_out.reached_zero = r_zero_out;
    assign o_out.live_count   = r_live;

    // every slot below the mark is either live or on the free stack
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_fdepth} + {1'b0, r_live}) == {1'b0, r_hw})
        else $error("free depth plus live count differs from high-water mark");

    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= CNT_W'(SLOT_COUNT))
        else $error("high-water mark beyond slot count");

    a_alloc_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == ght_pkg::OP_ALLOCATE && got)
        |=> r_live == $past(r_live) + CNT_W'(1))
        else $error("allocate did not bump live count");

endmodule

>>> rtl/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// slot map with generation-checked handles, lifo free stack and saturating
// reference counts
// ----------------------------------------------------------------------------
// usage
//   i_in carries one request beat: operation, handle, payload, type_tag.
//   o_out carries exactly one result beat per request, in request order.
//   handles are {generation[63:32], slot index + 1 [31:0]}; low half zero is
//   never valid.
// timing
//   a request is taken while idle and executed in the execute state: the slot
//   and free-stack memories are read at accept and written back at commit,
//   so one request occupies the block from accept to commit (read, then
//   write), and no new request is taken until it commits. the result sits
//   in an output register and shows up on o_out the cycle after commit.
// stalls
//   if o_out is still holding an untaken result, the executing request waits
//   before commit, and i_in.ready stays low until it commits.
// reset
//   synchronous, active low; clears the free stack depth, high-water mark,
//   live count and the output valid. memories are not cleared: slots are
//   written when the mark grows and the stack is used only below its depth.
// ----------------------------------------------------------------------------
module generational_handle_table #(
    parameter int unsigned SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ght_in_if.sink    i_in,
    ght_out_if.source o_out
);

    // control and status between sequencer and datapath
    ght_pkg::t_cmd  cmd;
    ght_pkg::t_stat stat;

    // sequencer: idle (ready) -> execute (commit when result register frees)
    ght_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: memories, table counters, handle check and result register
    ght_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

>>> sim/ght_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_checker
// watches the request and result channels of the handle table, keeps its own
// copy of the slot table to work out each result, and compares every result
// beat with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module ght_checker #(
    parameter int unsigned SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ght_in_if    i_req,
    ght_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    typedef struct packed {
        logic [ght_pkg::ST_W-1:0]      status;
        logic [ght_pkg::HANDLE_W-1:0]  new_handle;
        logic [ght_pkg::DATA_W-1:0]    payload_out;
        logic [ght_pkg::DATA_W-1:0]    type_out;
        logic [ght_pkg::REF_W-1:0]     ref_count;
        logic                          reached_zero;
        logic [ght_pkg::CNT_W_DEF-1:0] live_count;
    } t_result;

    // shadow slot table
    logic [ght_pkg::DATA_W-1:0] slot_pay  [SLOT_COUNT];
    logic [ght_pkg::DATA_W-1:0] slot_tag  [SLOT_COUNT];
    logic [ght_pkg::REF_W-1:0]  slot_refs [SLOT_COUNT];
    logic                       slot_live [SLOT_COUNT];
    logic [ght_pkg::GEN_W-1:0]  slot_gen  [SLOT_COUNT];
    int unsigned                recycled_slots[$];
    int unsigned                mark;
    int unsigned                live_slots;

    t_result           table_results[$];
    t_result           oldest;

    // one operation against the shadow table, returns the result it gives
    function automatic t_result apply_request(input logic [ght_pkg::OP_W-1:0] op,
                                              input logic [ght_pkg::HANDLE_W-1:0] hdl,
                                              input logic [ght_pkg::DATA_W-1:0] pay,
                                              input logic [ght_pkg::DATA_W-1:0] tag);
        t_result                   r;
        logic [ght_pkg::LOW_W-1:0] low;
        logic [ght_pkg::GEN_W-1:0] gen;
        int unsigned               idx;
        logic [ght_pkg::REF_W-1:0] prev;
        bit                        hit;
        r        = '0;
        r.status = ght_pkg::ST_INVALID;
        low      = hdl[ght_pkg::LOW_W-1:0];
        gen      = hdl[ght_pkg::HANDLE_W-1:ght_pkg::LOW_W];
        if (op == ght_pkg::OP_ALLOCATE) begin
            hit = 1'b1;
            if (recycled_slots.size() > 0) begin
                // most recently freed slot sits at the back
                idx = recycled_slots[$];
                recycled_slots.delete(recycled_slots.size() - 1);
            end else if (mark < SLOT_COUNT) begin
                idx           = mark;
                mark          = mark + 1;
                slot_gen[idx] = '0;
            end else begin
                hit = 1'b0;
            end
            if (hit) begin
                slot_pay[idx]  = pay;
                slot_tag[idx]  = tag;
                slot_refs[idx] = 1;
                slot_live[idx] = 1'b1;
                live_slots     = live_slots + 1;
                r.status       = ght_pkg::ST_OK;
                r.new_handle   = {slot_gen[idx], 32'(idx + 1)};
                r.ref_count    = 1;
            end else begin
                r.status = ght_pkg::ST_FULL;
            end
        end else if (op <= ght_pkg::OP_LOOKUP && low != '0 && (low - 32'd1) < mark) begin
            idx = low - 32'd1;
            if (slot_live[idx] && slot_gen[idx] == gen) begin
                r.status = ght_pkg::ST_OK;
                if (op == ght_pkg::OP_FREE) begin
                    slot_pay[idx]  = '0;
                    slot_live[idx] = 1'b0;
                    slot_refs[idx] = '0;
                    slot_gen[idx]  = slot_gen[idx] + 1;
                    recycled_slots = {recycled_slots, idx};
                    if (live_slots > 0) live_slots = live_slots - 1;
                end else if (op == ght_pkg::OP_ADD_REF) begin
                    if (slot_refs[idx] != ght_pkg::REF_MAX)
                        slot_refs[idx] = slot_refs[idx] + 1;
                    r.ref_count = slot_refs[idx];
                end else if (op == ght_pkg::OP_RELEASE) begin
                    prev = slot_refs[idx];
                    if (prev > 0) slot_refs[idx] = prev - 1;
                    r.reached_zero = (prev == 1);
                    r.ref_count    = slot_refs[idx];
                end else begin
                    r.payload_out = slot_pay[idx];
                    r.type_out    = slot_tag[idx];
                    r.ref_count   = slot_refs[idx];
                end
            end
        end
        r.live_count = ght_pkg::CNT_W_DEF'(live_slots);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        mark         = 0;
        live_slots   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mark       = 0;
            live_slots = 0;
            recycled_slots.delete();
            table_results.delete();
        end else begin
            // results first: a result can never belong to a request taken this edge
            if (i_res.valid && i_res.ready) begin
                o_checked++;
                if (table_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    o_fail_count++;
                end else begin
                    oldest = table_results.pop_front();
                    check_field("status", 64'(oldest.status), 64'(i_res.status));
                    check_field("new_handle", oldest.new_handle, i_res.new_handle);
                    check_field("payload_out", oldest.payload_out, i_res.payload_out);
                    check_field("type_out", oldest.type_out, i_res.type_out);
                    check_field("ref_count", 64'(oldest.ref_count), 64'(i_res.ref_count));
                    check_field("reached_zero", 64'(oldest.reached_zero),
                                64'(i_res.reached_zero));
                    check_field("live_count", 64'(oldest.live_count),
                                64'(i_res.live_count));
                end
            end
            if (i_req.valid && i_req.ready)
                table_results = {table_results,
                                 apply_request(i_req.operation, i_req.handle,
                                               i_req.payload, i_req.type_tag)};
        end
        o_pending = table_results.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives request beats into the generational handle table and throttles its
// result channel; a directed opening and a long random mix with a result
// hold-off, all judged by ght_checker
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RANDOM_ITEMS = 525;
    localparam int unsigned HOLD_CYCLES  = 120;

    logic i_clk;
    logic i_rst_n;

    ght_in_if  req_if ();
    ght_out_if res_if ();

    int fail_count;
    int pending;
    int checked;

    // stimulus knobs shared between the source and sink processes
    bit src_idles;
    bit sink_stalls;
    int hold_req;

    // handles seen coming back from allocate, and ones retired by free
    logic [ght_pkg::HANDLE_W-1:0] live_handles[$];
    logic [ght_pkg::HANDLE_W-1:0] stale_handles[$];
    int                           op_tally[8];

    generational_handle_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    ght_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("generational_handle_table verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result sink: random stall bursts, stretches of steady ready, and one long
    // hold-off when the stimulus asks for it
    // ------------------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                // long hold-off, counted here so the source keeps pushing beats
                res_if.ready = 1'b0;
                repeat (hold_req - 1) @(negedge i_clk);
                hold_req = 0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // collect handles handed out by the block so later beats can use them
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready &&
                res_if.status == ght_pkg::ST_OK && res_if.new_handle != '0)
                live_handles = {live_handles, res_if.new_handle};
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [ght_pkg::HANDLE_W-1:0] mk_handle(input int unsigned gen,
                                                               input int unsigned slot);
        return {32'(gen), 32'(slot + 1)};
    endfunction

    // mostly live handles, some stale, some damaged, some pure noise
    function automatic logic [ght_pkg::HANDLE_W-1:0] pick_handle();
        int                           sel;
        logic [ght_pkg::HANDLE_W-1:0] h;
        sel = $urandom_range(0, 19);
        h   = {$urandom, $urandom};
        if (sel < 15 && live_handles.size() > 0) begin
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        end else if (sel < 17 && stale_handles.size() > 0) begin
            h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
        end else if (sel == 17 && live_handles.size() > 0) begin
            // right slot, wrong generation
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            h[$urandom_range(ght_pkg::LOW_W, ght_pkg::HANDLE_W - 1)] ^= 1'b1;
        end else if (sel == 18) begin
            // zero low half or index past the table
            h[ght_pkg::LOW_W-1:0] = $urandom_range(0, 1) ? '0
                                                         : 32'($urandom_range(1025, 4096));
        end
        return h;
    endfunction

    // drop valid and idle the source; leaves the caller on a falling edge
    task automatic pause_source(input int n);
        @(negedge i_clk);
        req_if.valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // offer one request beat and hold it until the block takes it
    task automatic send_req(input logic [ght_pkg::OP_W-1:0] op,
                            input logic [ght_pkg::HANDLE_W-1:0] hdl,
                            input logic [ght_pkg::DATA_W-1:0] pay,
                            input logic [ght_pkg::DATA_W-1:0] tag);
        if (src_idles && $urandom_range(0, 4) == 0)
            pause_source($urandom_range(1, 9));
        @(negedge i_clk);
        req_if.valid     = 1'b1;
        req_if.operation = op;
        req_if.handle    = hdl;
        req_if.payload   = pay;
        req_if.type_tag  = tag;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        op_tally[op]++;
    endtask

    // one random beat; free retires its handle so later uses of it go stale
    task automatic random_req();
        int                           sel;
        int                           k;
        logic [ght_pkg::HANDLE_W-1:0] h;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            send_req(ght_pkg::OP_ALLOCATE, {$urandom, $urandom}, rand_word(), rand_word());
        end else if (sel < 40) begin
            if (live_handles.size() > 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, live_handles.size() - 1);
                h = live_handles[k];
                live_handles.delete(k);
                stale_handles = {stale_handles, h};
                if (stale_handles.size() > 32) void'(stale_handles.pop_front());
            end else begin
                h = pick_handle();
            end
            send_req(ght_pkg::OP_FREE, h, rand_word(), rand_word());
        end else if (sel < 55) begin
            send_req(ght_pkg::OP_ADD_REF, pick_handle(), rand_word(), rand_word());
        end else if (sel < 70) begin
            send_req(ght_pkg::OP_RELEASE, pick_handle(), rand_word(), rand_word());
        end else if (sel < 90) begin
            send_req(ght_pkg::OP_LOOKUP, pick_handle(), rand_word(), rand_word());
        end else begin
            // codes past lookup behave as a bad handle
            send_req(ght_pkg::OP_W'($urandom_range(5, 7)), pick_handle(), rand_word(),
                     rand_word());
        end
    endtask

    initial begin
        req_if.valid     = 1'b0;
        req_if.operation = ght_pkg::OP_LOOKUP;
        req_if.handle    = '0;
        req_if.payload   = '0;
        req_if.type_tag  = '0;
        src_idles        = 1'b1;
        sink_stalls      = 1'b1;
        hold_req         = 0;
        i_rst_n          = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --------------------------------------------------------------------
        // directed opening
        // --------------------------------------------------------------------
        // empty table: zero low half, then an index past the high-water mark
        send_req(ght_pkg::OP_LOOKUP, '0, '0, '0);
        send_req(ght_pkg::OP_LOOKUP, mk_handle(0, 0), '1, '1);
        // first two slots come from growing the mark, generation zero
        send_req(ght_pkg::OP_ALLOCATE, '1, '1, '1);
        send_req(ght_pkg::OP_ALLOCATE, '0, '0, '0);
        send_req(ght_pkg::OP_LOOKUP, mk_handle(0, 0), '0, '0);
        send_req(ght_pkg::OP_LOOKUP, mk_handle(0, 1), '0, '0);
        // count up, down to zero, and a release that stays pinned at zero
        send_req(ght_pkg::OP_ADD_REF, mk_handle(0, 0), '0, '0);
        send_req(ght_pkg::OP_RELEASE, mk_handle(0, 0), '0, '0);
        send_req(ght_pkg::OP_RELEASE, mk_handle(0, 0), '0, '0);
        send_req(ght_pkg::OP_RELEASE, mk_handle(0, 0), '0, '0);
        // count at zero keeps the slot alive
        send_req(ght_pkg::OP_LOOKUP, mk_handle(0, 0), '0, '0);
        // free bumps the generation: the old handle is stale afterwards
        send_req(ght_pkg::OP_FREE, mk_handle(0, 0), '0, '0);
        send_req(ght_pkg::OP_LOOKUP, mk_handle(0, 0), '0, '0);
        send_req(ght_pkg::OP_FREE, mk_handle(0, 0), '0, '0);
        // reuse comes back with generation one
        send_req(ght_pkg::OP_ALLOCATE, '0, 64'h0123_4567_89ab_cdef,
                 64'hfedc_ba98_7654_3210);
        send_req(ght_pkg::OP_LOOKUP, mk_handle(1, 0), '0, '0);
        send_req(ght_pkg::OP_W'(5), mk_handle(1, 0), '0, '0);
        send_req(ght_pkg::OP_W'(6), mk_handle(1, 0), '0, '0);
        send_req(ght_pkg::OP_W'(7), mk_handle(1, 0), '0, '0);
        send_req(ght_pkg::OP_ADD_REF, '1, '0, '0);
        // last freed slot is handed out first
        send_req(ght_pkg::OP_FREE, mk_handle(1, 0), '0, '0);
        send_req(ght_pkg::OP_FREE, mk_handle(0, 1), '0, '0);
        send_req(ght_pkg::OP_ALLOCATE, '0, '1, '0);
        send_req(ght_pkg::OP_ALLOCATE, '0, '0, '1);

        // --------------------------------------------------------------------
        // random mix with a long result hold-off, a full drain, and a quiet tail
        // --------------------------------------------------------------------
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 150)
                hold_req = HOLD_CYCLES;
            if (i == 300) begin
                pause_source(1);
                wait (pending == 0);
            end
            if (i == RANDOM_ITEMS - 100) begin
                src_idles   = 1'b0;
                sink_stalls = 1'b0;
            end
            random_req();
        end

        @(negedge i_clk);
        req_if.valid = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);

        $display("request beats: %0d allocate, %0d free, %0d add_ref, %0d release, %0d lookup,",
                 op_tally[0], op_tally[1], op_tally[2], op_tally[3], op_tally[4]);
        $display("  %0d unknown op; %0d results compared across stalls and a long hold-off",
                 op_tally[5] + op_tally[6] + op_tally[7], checked);
        if (fail_count == 0) begin
            $display("generational_handle_table verification clean");
        end else begin
            $display("generational_handle_table verification failed");
        end
        $finish;
    end

endmodule
